@@ hw/rtl/four_level_page_table_mapper_unit_macros.svh @@
// assertion macros used by the page table mapper datapath
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH

// clocked on clk_i, quiet while rst_ni is low
`define PTM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// plain same-cycle implication
`define PTM_ASSERT_IMP(name, ante, cons, msg) \
  `PTM_ASSERT(name, (ante) |-> (cons), msg)

`endif

@@ hw/rtl/ptm_pkg.sv @@
// types and constants of the four-level page table mapper
package ptm_pkg;

  localparam int POOL_TABLES_DEF   = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int PAGE_SHIFT        = 12;
  localparam int ENTRY_W           = 64;
  localparam int VA_W              = 48;
  localparam int PA_W              = 64;
  localparam int FLAGS_W           = 12;
  localparam int TIU_W             = 5;

  // low 12 bits of a pointer entry: present and writable
  localparam logic [PAGE_SHIFT-1:0] PTE_PTR_FLAGS = 12'h003;
  // present bit alone, ORed into a leaf entry
  localparam logic [PAGE_SHIFT-1:0] PTE_PRESENT   = 12'h001;

  // result status codes
  localparam logic STATUS_MAPPED    = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef logic [1:0] lvl_t;
  localparam lvl_t LVL_ROOT = 2'd0;
  localparam lvl_t LVL_LAST = 2'd2;  // last directory level before the leaf

  typedef struct packed {
    logic [VA_W-1:0]    virtual_address;
    logic [PA_W-1:0]    physical_address;
    logic [FLAGS_W-1:0] page_flags;
  } map_req_t;

  typedef struct packed {
    logic               status;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [TIU_W-1:0]   tables_in_use;
  } map_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load_input;
    logic follow;
    logic wr_ptr;
    logic wr_leaf;
    logic load_out;
    logic fail;
    lvl_t level;
  } ptm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic present;
    logic pool_full;
    logic out_free;
  } ptm_sts_t;

endpackage

@@ hw/rtl/ptm_ctrl.sv @@
// sequencer of the page table walk
module ptm_ctrl
  import ptm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ptm_sts_t sts_i,
  output ptm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_LEAF,
    ST_FINISH
  } state_e;

  state_e state_q;
  lvl_t   level_q;
  logic   fail_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.level      = level_q;
    cmd_o.fail       = fail_q;
    cmd_o.clear_wr   = (state_q == ST_CLEAR);
    cmd_o.load_input = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.follow     = (state_q == ST_EVAL) && sts_i.present;
    cmd_o.wr_ptr     = (state_q == ST_EVAL) && !sts_i.present && !sts_i.pool_full;
    cmd_o.wr_leaf    = (state_q == ST_LEAF);
    cmd_o.load_out   = (state_q == ST_FINISH) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      level_q <= LVL_ROOT;
      fail_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            level_q <= LVL_ROOT;
            fail_q  <= 1'b0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!sts_i.present && sts_i.pool_full) begin
            fail_q  <= 1'b1;
            state_q <= ST_FINISH;
          end else begin
            level_q <= level_q + 2'd1;
            state_q <= (level_q == LVL_LAST) ? ST_LEAF : ST_READ;
          end
        end
        ST_LEAF: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

endmodule

@@ hw/rtl/ptm_datapath.sv @@
// table memory, pool allocator, walk registers and result register
`include "four_level_page_table_mapper_unit_macros.svh"

module ptm_datapath
  import ptm_pkg::*;
#(
  parameter int POOL_TABLES = POOL_TABLES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  map_req_t in_req_i,
  input  ptm_cmd_t cmd_i,
  output ptm_sts_t sts_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output map_rsp_t out_rsp_o
);

  localparam int TW    = $clog2(POOL_TABLES);
  localparam int AW    = TW + IDX_W;
  localparam int DEPTH = POOL_TABLES * ENTRIES_PER_TABLE;
  localparam int CW    = $clog2(POOL_TABLES + 1);
  localparam int TN_W  = ENTRY_W - PAGE_SHIFT;

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  map_req_t           req_q;
  logic [TW-1:0]      cur_q;
  logic [CW-1:0]      nfree_q;
  logic [AW-1:0]      clr_q;
  logic               out_valid_q;
  map_rsp_t           out_rsp_q;

  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] ptr_entry;
  logic [ENTRY_W-1:0] leaf_entry;
  logic [TN_W-1:0]    ptr_tbl;
  logic [TW-1:0]      next_tbl;
  logic               pool_full;
  logic               out_free;

  // index bits for the current level
  always_comb begin
    case (cmd_i.level)
      2'd0:    idx = req_q.virtual_address[47:39];
      2'd1:    idx = req_q.virtual_address[38:30];
      2'd2:    idx = req_q.virtual_address[29:21];
      default: idx = req_q.virtual_address[20:12];
    endcase
  end

  assign pool_full  = (nfree_q >= CW'(POOL_TABLES));
  assign ptr_entry  = {{(TN_W - TW){1'b0}}, nfree_q[TW-1:0], PTE_PTR_FLAGS};
  assign leaf_entry = {req_q.physical_address[PA_W-1:PAGE_SHIFT],
                       req_q.page_flags | PTE_PRESENT};

  // table number held in a pointer entry, out of range reads as the root
  assign ptr_tbl  = rdata_q[ENTRY_W-1:PAGE_SHIFT];
  assign next_tbl = (ptr_tbl < TN_W'(POOL_TABLES)) ? ptr_tbl[TW-1:0] : '0;

  assign mem_addr = cmd_i.clear_wr ? clr_q : {cur_q, idx};
  assign mem_we   = cmd_i.clear_wr | cmd_i.wr_ptr | cmd_i.wr_leaf;
  always_comb begin
    if (cmd_i.clear_wr)    mem_wdata = '0;
    else if (cmd_i.wr_ptr) mem_wdata = ptr_entry;
    else                   mem_wdata = leaf_entry;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_input) req_q <= in_req_i;
    if (cmd_i.load_out) begin
      out_rsp_q.status        <= cmd_i.fail ? STATUS_EXHAUSTED : STATUS_MAPPED;
      out_rsp_q.leaf_entry    <= cmd_i.fail ? '0 : leaf_entry;
      out_rsp_q.tables_in_use <= TIU_W'(nfree_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      nfree_q     <= CW'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_wr) clr_q <= clr_q + AW'(1);
      if (cmd_i.load_input) begin
        cur_q <= '0;
      end else if (cmd_i.wr_ptr) begin
        cur_q <= nfree_q[TW-1:0];
      end else if (cmd_i.follow) begin
        cur_q <= next_tbl;
      end
      if (cmd_i.wr_ptr) nfree_q <= nfree_q + CW'(1);
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o            = '0;
    sts_o.clear_last = (clr_q == AW'(DEPTH - 1));
    sts_o.present    = rdata_q[0];
    sts_o.pool_full  = pool_full;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `PTM_ASSERT(a_pool_bound, nfree_q <= CW'(POOL_TABLES), "pool counter beyond pool size")
  `PTM_ASSERT_IMP(a_alloc_only_free, cmd_i.wr_ptr, !pool_full, "table taken from an empty pool")
  `PTM_ASSERT_IMP(a_load_out_free, cmd_i.load_out, out_free, "result overwrites a waiting result")
  `PTM_ASSERT(a_pool_step, !$past(cmd_i.wr_ptr) |-> $stable(nfree_q), "pool counter moved without an allocation")

endmodule

@@ hw/rtl/four_level_page_table_mapper_unit.sv @@
// top level of the four-level page table mapper
// Maps one virtual page per request into a store of POOL_TABLES page tables of 512
// 64-bit entries each, kept in a single-port memory inside the datapath. Bits 47..39,
// 38..30, 29..21 and 20..12 of the virtual address index the root, second, third and
// leaf levels; the root is table 0. A directory entry without its present bit gets the
// next table from a bump pool and becomes a present, writable pointer; the leaf entry is
// the frame address with the low 12 bits cleared, ORed with the flags and the present
// bit. When the pool is empty at a missing level the response carries status 1 and a
// zero leaf entry, and tables taken earlier in that walk stay taken. tables_in_use
// reports the pool count, root included, modulo 32. After reset the block sweeps the
// whole memory to zero, one entry a cycle, with in_ready_o low. in_ready_o is high only
// in the idle state, so a new request is taken only after the last one has loaded its
// response. A request walks each directory level as a memory read, then an evaluate
// step that, if needed, writes the pointer entry in the same port; it then writes the
// leaf entry and loads the response register. A request that runs out of tables
// finishes earlier, and a response still waiting in the output register holds the walk
// in its last cycle until the register is free.
// The response register lets the walk of the next request start while a response waits.
module four_level_page_table_mapper_unit
  import ptm_pkg::*;
#(
  parameter int POOL_TABLES = POOL_TABLES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // request channel
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  map_req_t in_req_i,
  // response channel
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output map_rsp_t out_rsp_o
);

  // command and status between sequencer and datapath
  ptm_cmd_t cmd;
  ptm_sts_t sts;

  // walk sequencer: clearing sweep, per-level read and evaluate, leaf write
  ptm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table memory, allocator and response register
  ptm_datapath #(
    .POOL_TABLES (POOL_TABLES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

@@ test/ptm_map_checker.sv @@
// request and response checker for the four-level page table mapper
module ptm_map_checker
  import ptm_pkg::*;
#(
  parameter int POOL_TABLES = POOL_TABLES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  map_req_t in_req_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  map_rsp_t out_rsp_i,
  output int       outstanding_o,
  output int       fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // sparse copy of the table store, absent slots read as zero
  logic [ENTRY_W-1:0] page_tables [int];
  int unsigned        next_table;
  map_rsp_t           predicted_rsp_q [$];
  int unsigned        error_count;

  function automatic map_rsp_t walk_and_map(input map_req_t req);
    map_rsp_t           rsp;
    logic [ENTRY_W-1:0] ent;
    logic [IDX_W-1:0]   idx;
    int unsigned        cur;
    int                 slot;
    bit                 failed;
    cur    = 0;
    failed = 1'b0;
    for (int lvl = 0; lvl < 3 && !failed; lvl++) begin
      idx  = req.virtual_address[VA_W-IDX_W-IDX_W*lvl +: IDX_W];
      slot = cur * ENTRIES_PER_TABLE + idx;
      ent  = page_tables.exists(slot) ? page_tables[slot] : '0;
      if (!ent[0]) begin
        if (next_table >= POOL_TABLES) begin
          failed = 1'b1;
        end else begin
          for (int e = 0; e < ENTRIES_PER_TABLE; e++) begin
            page_tables.delete(next_table * ENTRIES_PER_TABLE + e);
          end
          ent = {(ENTRY_W-PAGE_SHIFT)'(next_table), PTE_PTR_FLAGS};
          page_tables[slot] = ent;
          next_table++;
        end
      end
      if (!failed) begin
        cur = (ent[ENTRY_W-1:PAGE_SHIFT] < POOL_TABLES) ? int'(ent[ENTRY_W-1:PAGE_SHIFT]) : 0;
      end
    end
    rsp.leaf_entry = '0;
    if (!failed) begin
      rsp.leaf_entry = {req.physical_address[PA_W-1:PAGE_SHIFT], req.page_flags | PTE_PRESENT};
      page_tables[cur * ENTRIES_PER_TABLE + req.virtual_address[PAGE_SHIFT +: IDX_W]] =
        rsp.leaf_entry;
    end
    rsp.status        = failed ? STATUS_EXHAUSTED : STATUS_MAPPED;
    rsp.tables_in_use = TIU_W'(next_table);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    map_rsp_t want;
    if (!rst_ni) begin
      page_tables.delete();
      predicted_rsp_q.delete();
      next_table    = 1;
      error_count   = 0;
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predicted_rsp_q.push_back(walk_and_map(in_req_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_rsp_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%t: response with none pending: %p", $realtime, out_rsp_i);
          end
        end else begin
          want = predicted_rsp_q.pop_front();
          if (out_rsp_i.status !== want.status || out_rsp_i.leaf_entry !== want.leaf_entry ||
              out_rsp_i.tables_in_use !== want.tables_in_use) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%t: response mismatch, expected status %0d leaf %h tables %0d",
                       $realtime, want.status, want.leaf_entry, want.tables_in_use);
              $display("%t:                    got      status %0d leaf %h tables %0d",
                       $realtime, out_rsp_i.status, out_rsp_i.leaf_entry,
                       out_rsp_i.tables_in_use);
            end
          end
        end
      end
      outstanding_o <= predicted_rsp_q.size();
      fail_count_o  <= error_count;
    end
  end

endmodule

@@ test/four_level_page_table_mapper_unit_test.sv @@
// stimulus and verdict for the four-level page table mapper
module four_level_page_table_mapper_unit_test
  import ptm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_MAPS  = 1535;
  localparam int LONG_STALL   = 300;
  localparam int LIMIT_CYCLES = 400000;

  // receiver behaviour, picked afresh at random
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_PERIODIC
  } stall_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid    = 1'b0;
  logic     in_ready;
  map_req_t in_req      = '0;
  logic     out_valid;
  logic     out_ready   = 1'b0;
  map_rsp_t out_rsp;
  int       outstanding;
  int       fail_count;
  bit       long_stall_due = 1'b0;
  int       cycle_count;

  // walks that are fully built by the directed part; once the pool is
  // exhausted these are the only ones under which a new leaf can land
  logic [3*IDX_W-1:0] live_walks [6];

  four_level_page_table_mapper_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  ptm_map_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_rsp_i     (out_rsp),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: covers the clearing sweep after reset with a wide margin
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[four_level_page_table_mapper_unit] ERROR");
    $finish;
  end

  function automatic logic [VA_W-1:0] page_va(input int unsigned root, input int unsigned dir,
                                              input int unsigned mid, input int unsigned leaf,
                                              input int unsigned offs);
    return {IDX_W'(root), IDX_W'(dir), IDX_W'(mid), IDX_W'(leaf), PAGE_SHIFT'(offs)};
  endfunction

  function automatic map_req_t map_request(input logic [VA_W-1:0] va,
                                           input logic [PA_W-1:0] pa,
                                           input logic [FLAGS_W-1:0] fl);
    map_req_t req;
    req.virtual_address  = va;
    req.physical_address = pa;
    req.page_flags       = fl;
    return req;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic offer_map(input map_req_t req);
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic sender_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  // sender stops until every predicted response has been taken
  task automatic drain_responses();
    sender_gap(1);
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  // receiver: random stall pattern, plus one long hold-off on request
  initial begin
    stall_mode_e mode;
    int          mode_left;
    int          phase;
    mode      = RX_ALWAYS;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk_i);
      if (long_stall_due) begin
        // hold responses back so the block backs up and stalls requests
        out_ready <= 1'b0;
        for (int c = 1; c < LONG_STALL; c++) @(negedge clk_i);
        long_stall_due = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_ALWAYS:   out_ready <= 1'b1;
          RX_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
          RX_RARELY:   out_ready <= ($urandom_range(0, 3) == 0);
          default:     out_ready <= (phase % 5 == 0);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    logic [VA_W-1:0]    va;
    logic [3*IDX_W-1:0] walk;
    int                 burst_left;
    int                 pick;

    live_walks[0] = {9'd0,   9'd0,   9'd0};
    live_walks[1] = {9'd511, 9'd511, 9'd511};
    live_walks[2] = {9'd0,   9'd0,   9'd1};
    live_walks[3] = {9'd0,   9'd1,   9'd0};
    live_walks[4] = {9'd1,   9'd0,   9'd0};
    live_walks[5] = {9'd511, 9'd0,   9'd0};

    // single reset; the block then sweeps its store with ready low
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part; the comments track the pool count after each request
    // all-zero fields, fresh walk of three tables (4)
    offer_map(map_request(page_va(0, 0, 0, 0, 0), '0, '0));
    // all-one fields, second fresh walk (7)
    offer_map(map_request(page_va(511, 511, 511, 511, 12'hfff), '1, '1));
    // remap of an existing page, offset and frame low bits ignored
    offer_map(map_request(page_va(0, 0, 0, 0, 12'h123), 64'h0123_4567_89ab_cdef, 12'h800));
    // new leaf in an existing leaf table, no tables taken
    offer_map(map_request(page_va(0, 0, 0, 1, 0), 64'h8000_0000_0000_0fff, 12'h001));
    // one new level (8)
    offer_map(map_request(page_va(0, 0, 1, 0, 0), 64'h0000_0000_ffff_f000, 12'h7fe));
    // two new levels (10)
    offer_map(map_request(page_va(0, 1, 0, 0, 0), 64'haaaa_aaaa_aaaa_aaaa, 12'h555));
    // three new levels (13)
    offer_map(map_request(page_va(1, 0, 0, 0, 12'h800), 64'h5555_5555_5555_5555, 12'haaa));
    // two new levels under an existing root entry (15)
    offer_map(map_request(page_va(511, 0, 0, 0, 0), 64'hffff_ffff_0000_0000, 12'h0f0));
    // pool runs out mid-walk: one table taken, then exhausted (16)
    offer_map(map_request(page_va(2, 0, 0, 0, 0), 64'h1234_5000, 12'h00f));
    // the half-built walk now fails at its first missing level
    offer_map(map_request(page_va(2, 0, 5, 5, 0), 64'h1234_6000, 12'h00f));
    // fails right at the root
    offer_map(map_request(page_va(3, 7, 7, 7, 0), 64'h1234_7000, 12'h00f));
    // remap still works with the pool exhausted
    offer_map(map_request(page_va(511, 511, 511, 511, 0), 64'h5555_5555_5555_5555, 12'haaa));
    offer_map(map_request(page_va(2, 0, 0, 0, 0), '1, '1));
    offer_map(map_request(page_va(0, 0, 1, 511, 0), 64'hdead_beef_cafe_f00d, 12'h3c3));
    offer_map(map_request(page_va(511, 0, 0, 300, 12'h7ff), 64'h0f0f_0f0f_0f0f_0f0f, 12'hc3c));
    drain_responses();

    // random part: mostly new leaves under live walks, the rest noise
    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < RANDOM_MAPS; n++) begin
      pick = $urandom_range(0, 9);
      walk = live_walks[$urandom_range(0, 5)];
      if (pick < 8) begin
        va = {walk, IDX_W'($urandom), PAGE_SHIFT'($urandom)};
      end else if (pick == 8) begin
        // known root, the rest random: usually fails at a lower level
        va = {walk[3*IDX_W-1 -: IDX_W], (VA_W-IDX_W)'({$urandom, $urandom})};
      end else begin
        va = VA_W'({$urandom, $urandom});
      end
      offer_map(map_request(va, {$urandom, $urandom}, FLAGS_W'($urandom)));

      if (n == 300) begin
        long_stall_due = 1'b1;
      end
      if (n == 900) begin
        drain_responses();
      end

      burst_left--;
      if (burst_left == 0) begin
        sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
        burst_left = $urandom_range(1, 40);
      end
    end

    drain_responses();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[four_level_page_table_mapper_unit] OK");
    end else begin
      $display("[four_level_page_table_mapper_unit] ERROR");
    end
    $finish;
  end

endmodule
